/* rtl/core/sfd_pkg.sv */
// Shared constants, types and register codes of the stereo feedback delay.
`timescale 1ns / 1ps

package sfd_pkg;

  localparam int MAX_DELAY   = 262144;
  localparam int SAMPLE_BITS = 24;
  localparam int ADDR_BITS   = $clog2(MAX_DELAY);
  localparam int FILL_BITS   = ADDR_BITS + 1;

  localparam int GAIN_BITS  = 16;
  localparam int DELAY_BITS = 19;
  localparam int FRAC_BITS  = 15;

  // Width in which the next write position is compared with the delay length.
  localparam int CMP_BITS = (FILL_BITS > DELAY_BITS) ? FILL_BITS : DELAY_BITS;

  // Signed sample times a gain with a zero sign bit prepended.
  localparam int PROD_BITS = SAMPLE_BITS + GAIN_BITS + 1;
  // Sum of the input and the scaled feedback, with headroom for saturation.
  localparam int SUM_BITS  = SAMPLE_BITS + GAIN_BITS - FRAC_BITS + 2;

  localparam int FRAME_BITS = 2 * SAMPLE_BITS;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = DELAY_BITS;

  localparam logic [GAIN_BITS-1:0]  GAIN_RESET  = GAIN_BITS'(16384);
  localparam logic [DELAY_BITS-1:0] DELAY_RESET = DELAY_BITS'(24000);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_FEEDBACK_GAIN = 2'd0,
    CFG_DELAY_SAMPLES = 2'd1
  } cfg_index_t;

  // How a lane chooses the delayed sample for the item entering its multiplier.
  typedef struct packed {
    logic fwd_hit;  // take the result being written back by the item ahead
    logic filled;   // the entry has been written since reset
  } sfd_sel_t;

endpackage

/* rtl/core/sfd_frame_if.sv */
// Stereo frame channels: the input request and the result request.
`timescale 1ns / 1ps

interface sfd_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [sfd_pkg::SAMPLE_BITS-1:0] left_sample;
  logic signed [sfd_pkg::SAMPLE_BITS-1:0] right_sample;

  modport source (output valid, output left_sample, output right_sample, input ready);
  modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

interface sfd_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [sfd_pkg::SAMPLE_BITS-1:0] left_out;
  logic signed [sfd_pkg::SAMPLE_BITS-1:0] right_out;

  modport source (output valid, output left_out, output right_out, input ready);
  modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

/* rtl/core/sfd_ram.sv */
// Generic single-write, single-read memory with a registered read port.
`timescale 1ns / 1ps

module sfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/sfd_lane.sv */
// One channel's feedback path: delayed-sample select, gain multiply, add and saturate.
`timescale 1ns / 1ps

module sfd_lane (
  input  logic                                  clk,
  input  logic                                  load,
  input  logic signed [sfd_pkg::SAMPLE_BITS-1:0] x_in,
  input  logic        [sfd_pkg::SAMPLE_BITS-1:0] rd_data,
  input  logic        [sfd_pkg::SAMPLE_BITS-1:0] fwd_data,
  input  sfd_pkg::sfd_sel_t                     sel,
  input  logic        [sfd_pkg::GAIN_BITS-1:0]   gain,
  output logic signed [sfd_pkg::SAMPLE_BITS-1:0] result
);

  localparam int SB = sfd_pkg::SAMPLE_BITS;
  localparam int PB = sfd_pkg::PROD_BITS;
  localparam int NB = sfd_pkg::SUM_BITS;

  logic signed [SB-1:0] delayed;
  logic signed [PB-1:0] prod_next;
  logic signed [PB-1:0] prod;
  logic signed [SB-1:0] x;
  logic signed [PB-1:0] shifted;
  logic signed [NB-1:0] x_ext;
  logic signed [NB-1:0] fb_ext;
  logic signed [NB-1:0] sum;
  logic        [NB-SB:0] top;

  always_comb begin
    if (sel.fwd_hit) begin
      delayed = $signed(fwd_data);
    end else if (sel.filled) begin
      delayed = $signed(rd_data);
    end else begin
      delayed = '0;
    end
    prod_next = delayed * $signed({1'b0, gain});
  end

  always_ff @(posedge clk) begin
    if (load) begin
      prod <= prod_next;
      x    <= x_in;
    end
  end

  // The arithmetic shift floors the scaled product towards minus infinity.
  always_comb begin
    shifted = prod >>> sfd_pkg::FRAC_BITS;
    fb_ext  = $signed(shifted[NB-1:0]);
    x_ext   = {{(NB - SB){x[SB-1]}}, x};
    sum     = x_ext + fb_ext;
    top     = sum[NB-1:SB-1];
    if ((&top) || (~|top)) begin
      result = sum[SB-1:0];
    end else if (sum[NB-1]) begin
      result = {1'b1, {(SB - 1){1'b0}}};
    end else begin
      result = {1'b0, {(SB - 1){1'b1}}};
    end
  end

endmodule

/* rtl/core/stereo_feedback_delay_unit.sv */
// Top level of the stereo feedback delay: control pipeline, delay memory and two lanes.
`timescale 1ns / 1ps

// Each accepted stereo frame is added to its own delayed copy scaled by the feedback
// gain (unsigned Q1.15), saturated to the sample width, returned as the result and
// written back into the delay line at the shared write position. The block takes one
// frame per clock cycle unless an output stall or a hazard holds it, and returns each
// result through stage 1, stage 2 and the output register; the rate is set by the
// single delay memory, which holds both channels in one word and offers one read and
// one write port per cycle. When the delay length is one (or zero, which behaves the
// same), each frame needs the result of the frame just before it, so a frame then
// waits for the frame ahead to write back. No clearing pass is run after reset: a
// fill count records how far the write position has advanced since reset, and an
// entry at or beyond it reads as zero, so the block is ready in the first cycle after
// reset. Configuration writes should only be made while no frame is in flight.

module stereo_feedback_delay_unit (
  input  logic                                clk,
  input  logic                                rst,
  sfd_in_if.sink                              in_frame,
  sfd_out_if.source                           out_frame,
  input  logic                                cfg_write,
  input  logic [sfd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [sfd_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  localparam int AB = sfd_pkg::ADDR_BITS;
  localparam int FB = sfd_pkg::FILL_BITS;
  localparam int SB = sfd_pkg::SAMPLE_BITS;
  localparam int CB = sfd_pkg::CMP_BITS;

  // Configuration registers.
  logic [sfd_pkg::GAIN_BITS-1:0]  feedback_gain;
  logic [sfd_pkg::DELAY_BITS-1:0] delay_samples;

  always_ff @(posedge clk) begin
    if (rst) begin
      feedback_gain <= sfd_pkg::GAIN_RESET;
      delay_samples <= sfd_pkg::DELAY_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        sfd_pkg::CFG_FEEDBACK_GAIN: feedback_gain <= cfg_data[sfd_pkg::GAIN_BITS-1:0];
        sfd_pkg::CFG_DELAY_SAMPLES: delay_samples <= cfg_data;
        default: ;
      endcase
    end
  end

  // Write position and fill count.
  logic [AB-1:0] pos;
  logic [AB-1:0] pos_next;
  logic [FB-1:0] fill;
  logic [CB-1:0] pos_inc;

  // Pipeline control: stage 1 waits for the memory read, stage 2 holds the product and
  // writes back, the output register presents the result.
  logic          s1_valid;
  logic [AB-1:0] s1_pos;
  logic signed [SB-1:0] s1_left_x;
  logic signed [SB-1:0] s1_right_x;
  sfd_pkg::sfd_sel_t    s1_sel;
  logic [SB-1:0] s1_fwd_left;
  logic [SB-1:0] s1_fwd_right;

  logic          s2_valid;
  logic [AB-1:0] s2_pos;

  logic                 out_valid;
  logic signed [SB-1:0] out_left;
  logic signed [SB-1:0] out_right;

  logic s1_adv;
  logic s2_adv;
  logic hazard;
  logic accept;
  logic fwd_now;
  logic filled_now;

  logic signed [SB-1:0]         left_res;
  logic signed [SB-1:0]         right_res;
  logic [sfd_pkg::FRAME_BITS-1:0] rd_frame;

  always_comb begin
    s2_adv = s2_valid && (!out_valid || out_frame.ready);
    s1_adv = s1_valid && (!s2_valid || s2_adv);
    // A frame may not enter stage 1 while the frame just ahead of it, at the same
    // position, has yet to produce its result. A frame ahead that writes back in
    // this very cycle is forwarded instead.
    hazard = (s1_valid && (s1_pos == pos)) ||
             (s2_valid && (s2_pos == pos) && !s2_adv);
    fwd_now    = s2_adv && (s2_pos == pos);
    filled_now = ({1'b0, pos} < fill);
  end

  assign in_frame.ready = (!s1_valid || s1_adv) && !hazard;
  assign accept         = in_frame.valid && in_frame.ready;

  // The position wraps when it reaches the delay length or the store depth.
  always_comb begin
    pos_inc = CB'(pos) + CB'(1);
    if ((pos_inc >= CB'(delay_samples)) || (pos_inc >= CB'(sfd_pkg::MAX_DELAY))) begin
      pos_next = '0;
    end else begin
      pos_next = pos_inc[AB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (accept) begin
      pos <= pos_next;
    end
  end

  // Positions are first reached in increasing order, so the entries written since
  // reset are always those below the fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (s2_adv && ({1'b0, s2_pos} == fill)) begin
      fill <= fill + FB'(1);
    end
  end

  // Stage 1.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pos         <= pos;
      s1_left_x      <= in_frame.left_sample;
      s1_right_x     <= in_frame.right_sample;
      s1_sel.fwd_hit <= fwd_now;
      s1_sel.filled  <= filled_now;
      s1_fwd_left    <= left_res;
      s1_fwd_right   <= right_res;
    end
  end

  // Stage 2.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_adv) begin
      s2_valid <= 1'b1;
    end else if (s2_adv) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_pos <= s1_pos;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_adv) begin
      out_valid <= 1'b1;
    end else if (out_frame.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      out_left  <= left_res;
      out_right <= right_res;
    end
  end

  assign out_frame.valid     = out_valid;
  assign out_frame.left_out  = out_left;
  assign out_frame.right_out = out_right;

  // Both delay lines share one memory word: left in the upper half, right below.
  sfd_ram #(
    .WIDTH (sfd_pkg::FRAME_BITS),
    .DEPTH (sfd_pkg::MAX_DELAY)
  ) u_line (
    .clk   (clk),
    .we    (s2_adv),
    .waddr (s2_pos),
    .wdata ({left_res, right_res}),
    .re    (accept),
    .raddr (pos),
    .rdata (rd_frame)
  );

  sfd_lane u_left (
    .clk      (clk),
    .load     (s1_adv),
    .x_in     (s1_left_x),
    .rd_data  (rd_frame[2*SB-1:SB]),
    .fwd_data (s1_fwd_left),
    .sel      (s1_sel),
    .gain     (feedback_gain),
    .result   (left_res)
  );

  sfd_lane u_right (
    .clk      (clk),
    .load     (s1_adv),
    .x_in     (s1_right_x),
    .rd_data  (rd_frame[SB-1:0]),
    .fwd_data (s1_fwd_right),
    .sel      (s1_sel),
    .gain     (feedback_gain),
    .result   (right_res)
  );

  // Two frames in adjacent stages never share a position: the second would have read
  // a stale entry.
  a_no_adjacent_same_pos: assert property (@(posedge clk) disable iff (rst)
    !(s1_valid && s2_valid && (s1_pos == s2_pos)))
    else $error("adjacent frames share a delay position");

  // A write-back never lands beyond the fill count, or the fill record would be wrong.
  a_write_within_fill: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> ({1'b0, s2_pos} <= fill))
    else $error("write-back beyond the fill count");

  // The fill count never passes the store depth.
  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    fill <= FB'(sfd_pkg::MAX_DELAY))
    else $error("fill count exceeds the store depth");

  // Once a frame has taken a forwarded result, the frame that supplied it has left
  // stage 2, so no frame at the same position sits there on the next cycle.
  a_fwd_source: assert property (@(posedge clk) disable iff (rst)
    (accept && fwd_now) |=> (s1_valid && s1_sel.fwd_hit && s2_valid && (s2_pos == s1_pos)) == 1'b0)
    else $error("forwarded frame follows a frame at the same position");

endmodule
